>>> rtl/core/adbd_pkg.sv
// ----------------------------------------------------------------------------
// adbd_pkg
// Types, constants and filter weight lookups shared by the block ADPCM decoder.
// ----------------------------------------------------------------------------
package adbd_pkg;

   // Command handed from the front end to the back end through the queue.
   typedef struct packed {
      logic       clear;    // header or flag byte ending a sound: clear predictors only
      logic       last;     // data byte that ends a sound
      logic [3:0] filter;
      logic [3:0] shift;
      logic [7:0] data;
   } cmd_type;

   // One decoded result as it waits in the result queue.
   typedef struct packed {
      logic signed [15:0] sample_s16;
      logic [7:0]         sample_u8;
      logic               last_of_run;
      logic               sound_done;
   } result_type;

   localparam int unsigned SUM_WIDTH = 19;

   localparam logic signed [SUM_WIDTH-1:0] SAMPLE_MAX = 19'sd32767;
   localparam logic signed [SUM_WIDTH-1:0] SAMPLE_MIN = -19'sd32768;

   localparam logic [3:0] HEADER_POS = 4'd0;
   localparam logic [3:0] FLAGS_POS  = 4'd1;

   // Weight applied to the most recent sample; filters 5 to 15 act as filter 0.
   function automatic logic signed [7:0] weight_new(input logic [3:0] filter);
      logic signed [7:0] w;
      begin
         case (filter)
            4'd1:    w = 8'sd60;
            4'd2:    w = 8'sd115;
            4'd3:    w = 8'sd98;
            4'd4:    w = 8'sd122;
            default: w = 8'sd0;
         endcase
         return w;
      end
   endfunction

   // Weight applied to the sample before that.
   function automatic logic signed [7:0] weight_old(input logic [3:0] filter);
      logic signed [7:0] w;
      begin
         case (filter)
            4'd2:    w = -8'sd52;
            4'd3:    w = -8'sd55;
            4'd4:    w = -8'sd60;
            default: w = 8'sd0;
         endcase
         return w;
      end
   endfunction

endpackage

>>> rtl/core/adbd_fifo.sv
// ----------------------------------------------------------------------------
// adbd_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module adbd_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = PTR_WIDTH + 1;
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);

   logic [WIDTH-1:0]     store_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // Pointers wrap at the last entry so that any depth works.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/adbd_front.sv
// ----------------------------------------------------------------------------
// adbd_front
// Tracks the byte position in the block, captures the header and turns each
// data byte, or a byte that ends a sound, into a decode or clear command.
// ----------------------------------------------------------------------------
module adbd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                end_of_sound,
   output logic                cmd_push,
   output adbd_pkg::cmd_type   cmd_data
);

   logic [3:0] byte_pos_ff, byte_pos_in;
   logic [3:0] filter_ff, filter_in;
   logic [3:0] shift_ff, shift_in;
   logic       is_data;

   assign is_data = (byte_pos_ff != adbd_pkg::HEADER_POS) &&
                    (byte_pos_ff != adbd_pkg::FLAGS_POS);

   // A header or flag byte that ends a sound still has to clear the predictors.
   assign cmd_push        = accept && (is_data || end_of_sound);
   assign cmd_data.clear  = !is_data;
   assign cmd_data.last   = end_of_sound;
   assign cmd_data.filter = filter_ff;
   assign cmd_data.shift  = shift_ff;
   assign cmd_data.data   = data_byte;

   always_comb begin
      byte_pos_in = byte_pos_ff;
      filter_in   = filter_ff;
      shift_in    = shift_ff;
      if (accept) begin
         byte_pos_in = byte_pos_ff + 1'b1;
         if (byte_pos_ff == adbd_pkg::HEADER_POS) begin
            filter_in = data_byte[7:4];
            shift_in  = data_byte[3:0];
         end
         if (end_of_sound) begin
            byte_pos_in = '0;
            filter_in   = '0;
            shift_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         filter_ff   <= '0;
         shift_ff    <= '0;
      end else begin
         byte_pos_ff <= byte_pos_in;
         filter_ff   <= filter_in;
         shift_ff    <= shift_in;
      end
   end

endmodule

>>> rtl/core/adbd_back.sv
// ----------------------------------------------------------------------------
// adbd_back
// Decodes the two nibbles of each data command into samples: a multiply
// step forms the weighted predictors, then a sum step clamps and emits.
// ----------------------------------------------------------------------------
module adbd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  adbd_pkg::cmd_type     cmd_data,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   output logic                  rsp_push,
   output adbd_pkg::result_type  rsp_data,
   input  logic                  rsp_full
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM
   } state_type;

   localparam int unsigned SW = adbd_pkg::SUM_WIDTH;

   state_type                state_ff, state_in;
   adbd_pkg::cmd_type        cmd_ff, cmd_in;
   logic                     half_ff, half_in;
   logic signed [15:0]       prev_ff, prev_in;
   logic signed [15:0]       older_ff, older_in;
   logic signed [15:0]       base_ff, base_in;
   logic signed [23:0]       p0_ff, p0_in;
   logic signed [23:0]       p1_ff, p1_in;
   logic [3:0]               nibble;
   logic signed [15:0]       nibble_word;
   logic signed [SW-1:0]     sum;
   logic signed [15:0]       clamped;
   logic                     commit;

   assign cmd_pop  = (state_ff == ST_IDLE) && !cmd_empty;
   assign commit   = (state_ff == ST_SUM) && !rsp_full;
   assign rsp_push = commit;

   assign nibble      = half_ff ? cmd_ff.data[7:4] : cmd_ff.data[3:0];
   assign nibble_word = {nibble, 12'b0};

   // The products are floored by dropping their low six bits.
   assign sum = SW'(base_ff) + SW'($signed(p0_ff[23:6])) + SW'($signed(p1_ff[23:6]));

   always_comb begin
      if (sum > adbd_pkg::SAMPLE_MAX) begin
         clamped = 16'sh7fff;
      end else if (sum < adbd_pkg::SAMPLE_MIN) begin
         clamped = 16'sh8000;
      end else begin
         clamped = sum[15:0];
      end
   end

   assign rsp_data.sample_s16  = clamped;
   assign rsp_data.sample_u8   = {~clamped[15], clamped[14:8]};
   assign rsp_data.last_of_run = half_ff;
   assign rsp_data.sound_done  = half_ff && cmd_ff.last;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      half_in  = half_ff;
      prev_in  = prev_ff;
      older_in = older_ff;
      base_in  = base_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               if (cmd_data.clear) begin
                  prev_in  = '0;
                  older_in = '0;
               end else begin
                  cmd_in   = cmd_data;
                  half_in  = 1'b0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            base_in  = nibble_word >>> cmd_ff.shift;
            p0_in    = prev_ff * adbd_pkg::weight_new(cmd_ff.filter);
            p1_in    = older_ff * adbd_pkg::weight_old(cmd_ff.filter);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (commit) begin
               older_in = prev_ff;
               prev_in  = clamped;
               if (!half_ff) begin
                  half_in  = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  if (cmd_ff.last) begin
                     prev_in  = '0;
                     older_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         half_ff  <= 1'b0;
         prev_ff  <= '0;
         older_ff <= '0;
      end else begin
         state_ff <= state_in;
         half_ff  <= half_in;
         prev_ff  <= prev_in;
         older_ff <= older_in;
      end
      cmd_ff  <= cmd_in;
      base_ff <= base_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
   end

   // The products must be ready before every sum.
   mul_then_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |=> state_ff == ST_SUM)
      else $error("multiply step not followed by sum step");

   // While the result queue is full the sum step waits on unchanged operands.
   stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && rsp_full) |=>
         (state_ff == ST_SUM && $stable(p0_ff) && $stable(p1_ff) && $stable(prev_ff)))
      else $error("sum step operands changed during stall");

   // The predictors shift by one sample on each result within a sound.
   history_shift: assert property (@(posedge clock) disable iff (reset)
      (commit && !(half_ff && cmd_ff.last)) |=> older_ff == $past(prev_ff))
      else $error("predictor history not shifted");

   // The final sample of a sound leaves clean predictors behind.
   sound_end_clear: assert property (@(posedge clock) disable iff (reset)
      (commit && half_ff && cmd_ff.last) |=> (prev_ff == '0 && older_ff == '0))
      else $error("predictors not cleared at end of sound");

endmodule

>>> rtl/core/adpcm_block_decoder_unit.sv
// An accepted byte waits in the command queue, which takes new requests while
// the back end is busy. A data byte's low nibble runs the back end's multiply
// and sum steps and its high nibble runs them again; a sum step waits while
// the result queue is full. Header and flag bytes are queued only to end a
// sound, and then only clear the predictors. Reset clears both predictors,
// the header fields, the byte position and both queues.
// ----------------------------------------------------------------------------
// adpcm_block_decoder_unit
// Block ADPCM decoder: a front end that tracks the block layout, a command
// queue, a back end that reconstructs samples, and a result queue.
// ----------------------------------------------------------------------------
module adpcm_block_decoder_unit #(
   parameter int unsigned CMD_DEPTH = 2,
   parameter int unsigned RSP_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_sound,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_sample_s16,
   output logic [7:0]         rsp_sample_u8,
   output logic               rsp_last_of_run,
   output logic               rsp_sound_done
);

   localparam int unsigned CMD_WIDTH = $bits(adbd_pkg::cmd_type);
   localparam int unsigned RSP_WIDTH = $bits(adbd_pkg::result_type);

   logic                  accept;
   logic                  cmd_push;
   adbd_pkg::cmd_type     cmd_in_data;
   adbd_pkg::cmd_type     cmd_out_data;
   logic                  cmd_empty;
   logic                  cmd_pop;
   logic                  result_push;
   adbd_pkg::result_type  result_in_data;
   adbd_pkg::result_type  result_out_data;
   logic                  result_full;

   assign accept = req_push && !req_full;

   adbd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .end_of_sound (req_end_of_sound),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_in_data)
   );

   adbd_fifo #(
      .WIDTH (CMD_WIDTH),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   adbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_out_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (result_push),
      .rsp_data  (result_in_data),
      .rsp_full  (result_full)
   );

   adbd_fifo #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result_in_data),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (result_out_data),
      .empty     (rsp_empty)
   );

   assign rsp_sample_s16  = result_out_data.sample_s16;
   assign rsp_sample_u8   = result_out_data.sample_u8;
   assign rsp_last_of_run = result_out_data.last_of_run;
   assign rsp_sound_done  = result_out_data.sound_done;

endmodule

>>> sim/tb_adpcm_block_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_adpcm_block_decoder_unit
// Self-checking bench for the block ADPCM decoder. Byte requests go in through
// the push/full queue and every accepted request is run through a local
// decoder model that queues the two samples a data byte should produce.
// Samples popped from the result queue are checked field by field against
// that queue. A short directed table comes first, then random sounds and
// noise under three idling patterns, one of them with a long receiver stall.
// ----------------------------------------------------------------------------
module tb_adpcm_block_decoder_unit;

   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int unsigned DRAIN_CYCLES     = 20;
   localparam int unsigned LONG_HOLD        = 300;
   localparam int unsigned PHASE_DATA_BYTES = 580;
   localparam int unsigned DIRECTED_COUNT   = 25;
   localparam int unsigned BLOCK_BYTES      = 16;

   // One request of the directed table. When typed is set, the sample values
   // of the row replace the model's values for that byte.
   typedef struct packed {
      logic [7:0]         data;
      logic               eos;
      logic               typed;
      logic signed [15:0] lo_s16;
      logic [7:0]         lo_u8;
      logic signed [15:0] hi_s16;
      logic [7:0]         hi_u8;
   } stim_row_type;

   localparam stim_row_type DIRECTED [DIRECTED_COUNT] = '{
      // Filter 0, shift 0: the code goes straight to the sample.
      '{8'h00, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'hFF, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h00, 1'b0, 1'b1, 16'sd0, 8'd128, 16'sd0, 8'd128},
      '{8'h87, 1'b0, 1'b1, 16'sd28672, 8'd240, 16'sh8000, 8'd0},
      '{8'h7F, 1'b0, 1'b1, -16'sd4096, 8'd112, 16'sd28672, 8'd240},
      '{8'h5A, 1'b1, 1'b1, -16'sd24576, 8'd32, 16'sd20480, 8'd208},
      // Filter 4 with full-scale codes drives the sum into both clamps.
      '{8'h40, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h77, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h88, 1'b1, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      // End of sound on a header byte, then on a flag byte.
      '{8'h3D, 1'b1, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h2F, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'hAA, 1'b1, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      // Filters 1 to 3 with the large shift amounts.
      '{8'h1E, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h55, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h81, 1'b1, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h2F, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h87, 1'b1, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h3C, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'hF7, 1'b1, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      // Filter 15 acts as filter 0; shift 13 leaves little more than the sign.
      '{8'hFD, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 16'sd0, 8'd0, 16'sd0, 8'd0},
      '{8'h7F, 1'b1, 1'b1, -16'sd1, 8'd127, 16'sd3, 8'd128}
   };

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_push         = 1'b0;
   logic               req_full;
   logic [7:0]         req_data_byte    = 8'h00;
   logic               req_end_of_sound = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop          = 1'b0;
   logic signed [15:0] rsp_sample_s16;
   logic [7:0]         rsp_sample_u8;
   logic               rsp_last_of_run;
   logic               rsp_sound_done;

   // Decoder model state.
   logic signed [15:0] newest_smp = '0;
   logic signed [15:0] older_smp  = '0;
   logic [3:0]         hdr_filter = '0;
   logic [3:0]         hdr_shift  = '0;
   logic [3:0]         block_pos  = '0;
   int unsigned        data_bytes_seen = 0;

   adbd_pkg::result_type expected_samples [$];
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   int unsigned stall_requests = 0;
   int unsigned stall_served   = 0;
   int unsigned hold_left      = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;

   adpcm_block_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_end_of_sound (req_end_of_sound),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_sample_s16   (rsp_sample_s16),
      .rsp_sample_u8    (rsp_sample_u8),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_sound_done   (rsp_sound_done)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Turns one 4-bit code into a sample and shifts the predictor history.
   function automatic adbd_pkg::result_type decode_code(input logic [3:0] code);
      adbd_pkg::result_type res;
      logic signed [31:0]   code_val;
      int                   w_new;
      int                   w_old;
      int                   acc;
      case (hdr_filter)
         4'd1: begin
            w_new = 60;
            w_old = 0;
         end
         4'd2: begin
            w_new = 115;
            w_old = -52;
         end
         4'd3: begin
            w_new = 98;
            w_old = -55;
         end
         4'd4: begin
            w_new = 122;
            w_old = -60;
         end
         default: begin
            w_new = 0;
            w_old = 0;
         end
      endcase
      code_val = {{16{code[3]}}, code, 12'h000};
      acc = int'(code_val >>> hdr_shift)
            + ((int'(newest_smp) * w_new) >>> 6)
            + ((int'(older_smp) * w_old) >>> 6);
      if (acc > 32767) begin
         acc = 32767;
      end else if (acc < -32768) begin
         acc = -32768;
      end
      older_smp  = newest_smp;
      newest_smp = acc[15:0];
      res.sample_s16  = acc[15:0];
      res.sample_u8   = 8'((acc + 32768) >> 8);
      res.last_of_run = 1'b0;
      res.sound_done  = 1'b0;
      return res;
   endfunction

   // Advances the model by one accepted byte; n is the number of samples made.
   task automatic decode_request(input logic [7:0] b, input logic eos, output int n,
                                 output adbd_pkg::result_type lo,
                                 output adbd_pkg::result_type hi);
      n  = 0;
      lo = '0;
      hi = '0;
      if (block_pos == adbd_pkg::HEADER_POS) begin
         hdr_filter = b[7:4];
         hdr_shift  = b[3:0];
      end else if (block_pos != adbd_pkg::FLAGS_POS) begin
         lo = decode_code(b[3:0]);
         hi = decode_code(b[7:4]);
         hi.last_of_run = 1'b1;
         hi.sound_done  = eos;
         n = 2;
         data_bytes_seen++;
      end
      block_pos = block_pos + 4'd1;
      if (eos) begin
         newest_smp = '0;
         older_smp  = '0;
         hdr_filter = '0;
         hdr_shift  = '0;
         block_pos  = '0;
      end
   endtask

   // Offers one request, waits until it is taken, and queues its samples.
   // The push line is only lowered while idling, never between two
   // back-to-back requests.
   task automatic send_item(input stim_row_type row);
      int                   n;
      adbd_pkg::result_type lo;
      adbd_pkg::result_type hi;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_data_byte    <= row.data;
      req_end_of_sound <= row.eos;
      do @(posedge clock); while (req_full);
      decode_request(row.data, row.eos, n, lo, hi);
      if (row.typed) begin
         lo.sample_s16 = row.lo_s16;
         lo.sample_u8  = row.lo_u8;
         hi.sample_s16 = row.hi_s16;
         hi.sample_u8  = row.hi_u8;
      end
      if (n == 2) begin
         expected_samples.push_back(lo);
         expected_samples.push_back(hi);
      end
   endtask

   function automatic stim_row_type plain_row(input logic [7:0] b, input logic eos);
      stim_row_type row;
      row       = '0;
      row.data  = b;
      row.eos   = eos;
      return row;
   endfunction

   // A well-formed sound of one to three blocks. Some sounds are cut short
   // by an early end marker, and some run on without one so that the next
   // sound continues with the same predictor history.
   task automatic send_sound();
      int unsigned blocks;
      int unsigned last_idx;
      int unsigned shape;
      logic        open_end;
      logic [3:0]  filt;
      logic [3:0]  shft;
      logic [7:0]  b;
      blocks   = $urandom_range(3, 1);
      last_idx = blocks * BLOCK_BYTES - 1;
      shape    = $urandom_range(99);
      open_end = 1'b0;
      if (shape < 10) begin
         last_idx = $urandom_range(last_idx);
      end else if (shape < 18) begin
         open_end = 1'b1;
      end
      for (int unsigned k = 0; k <= last_idx; k++) begin
         if (k % BLOCK_BYTES == 0) begin
            filt = ($urandom_range(99) < 85) ? 4'($urandom_range(4)) : 4'($urandom);
            shft = ($urandom_range(99) < 80) ? 4'($urandom_range(12)) : 4'($urandom);
            b    = {filt, shft};
         end else begin
            b = 8'($urandom);
         end
         send_item(plain_row(b, (k == last_idx) && !open_end));
      end
   endtask

   // Random bytes with stray end markers; the last one always ends the
   // sound so that the following sound starts on a block header.
   task automatic send_noise();
      int unsigned count;
      count = $urandom_range(40, 1);
      for (int unsigned k = 0; k < count; k++) begin
         send_item(plain_row(8'($urandom), (k == count - 1) || ($urandom_range(99) < 6)));
      end
   endtask

   task automatic run_random(input int unsigned target);
      int unsigned start;
      start = data_bytes_seen;
      while (data_bytes_seen - start < target) begin
         if ($urandom_range(99) < 85) begin
            send_sound();
         end else begin
            send_noise();
         end
      end
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Result side: checks each popped sample and decides the next pop.
   always @(posedge clock) begin : pop_side
      adbd_pkg::result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_samples.size() == 0) begin
               error_count++;
               $display("%0t: unexpected sample: expected none, actual s16=%0d u8=%0d %s",
                        $time, rsp_sample_s16, rsp_sample_u8,
                        $sformatf("last_of_run=%0b sound_done=%0b",
                                  rsp_last_of_run, rsp_sound_done));
            end else begin
               want = expected_samples.pop_front();
               check_field("sample_s16", want.sample_s16, rsp_sample_s16);
               check_field("sample_u8", want.sample_u8, rsp_sample_u8);
               check_field("last_of_run", want.last_of_run, rsp_last_of_run);
               check_field("sound_done", want.sound_done, rsp_sound_done);
            end
         end
         if (stall_served != stall_requests) begin
            stall_served <= stall_requests;
            hold_left    <= LONG_HOLD;
            rsp_pop      <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_pop   <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d samples outstanding", $time, expected_samples.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      send_idle_pct = 36;
      recv_idle_pct = 67;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int unsigned i = 0; i < DIRECTED_COUNT; i++) begin
         send_item(DIRECTED[i]);
      end
      run_random(PHASE_DATA_BYTES);

      send_idle_pct = 67;
      recv_idle_pct = 36;
      run_random(PHASE_DATA_BYTES);

      // No idling on either side; the receiver first holds off for a long
      // stretch while requests keep coming, so both queues fill up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_requests++;
      run_random(PHASE_DATA_BYTES);

      req_push <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/adbd_pkg.sv
rtl/core/adbd_fifo.sv
rtl/core/adbd_front.sv
rtl/core/adbd_back.sv
rtl/core/adpcm_block_decoder_unit.sv
sim/tb_adpcm_block_decoder_unit.sv
